// ===== design/stre_pkg.sv =====
// stre_pkg: shared constants, types and the quarter-wave sine table for the
// sine tone generator with ramp envelope. No dependencies.
`timescale 1ns / 1ps

package stre_pkg;

    // Table and counter sizing
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned INDEX_BITS      = 24;
    localparam int unsigned TBL_N           = 1 << SINE_TABLE_BITS;
    localparam int unsigned ROM_ADDR_W      = SINE_TABLE_BITS + 1;

    // Field widths
    localparam int unsigned PHASE_W   = 32;
    localparam int unsigned AMP_W     = 15;
    localparam int unsigned TOTAL_W   = 24;
    localparam int unsigned RLEN_W    = 16;
    localparam int unsigned RSTEP_W   = 31;
    localparam int unsigned SINE_W    = 15;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned QTURN_BIT = 30;

    // Bit-serial multiplier: multiplicand is as wide as ramp_step, the
    // multiplier operand covers a sample index or a segment length.
    localparam int unsigned MUL_A_W = RSTEP_W;
    localparam int unsigned MUL_B_W = (INDEX_BITS > TOTAL_W) ? INDEX_BITS : TOTAL_W;
    localparam int unsigned CMP_W   = MUL_B_W + 1;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned STEP_W  = $clog2(MUL_B_W);

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP    = 3'd0,
        CFG_AMPLITUDE     = 3'd1,
        CFG_TOTAL_SAMPLES = 3'd2,
        CFG_RAMP_SAMPLES  = 3'd3,
        CFG_RAMP_STEP     = 3'd4
    } stre_cfg_idx_t;

    localparam logic [PHASE_W-1:0] RST_PHASE_STEP    = PHASE_W'(140458852);
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE     = AMP_W'(4200);
    localparam logic [TOTAL_W-1:0] RST_TOTAL_SAMPLES = TOTAL_W'(2240);
    localparam logic [RLEN_W-1:0]  RST_RAMP_SAMPLES  = RLEN_W'(400);
    localparam logic [RSTEP_W-1:0] RST_RAMP_STEP     = RSTEP_W'(2684355);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_MUL_ENV,
        ST_GAIN_RD,
        ST_MUL_AMP,
        ST_LOAD_GAIN,
        ST_MUL_GAIN,
        ST_DONE
    } stre_state_t;

    // Quarter-wave table, 32767 * sin(pi/2 * k / TBL_N), k = 0 .. TBL_N.
    // Built at elaboration from a Q30 Taylor series.
    typedef logic [SINE_W-1:0] sine_tbl_t [0:TBL_N];

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Restoring shift-subtract quotient, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] divisor);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, divisor})
            begin
                rem    = rem - {1'b0, divisor};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t   tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] den;
        for (int unsigned k = 0; k <= TBL_N; k++)
        begin
            x    = (64'(k) * PI_HALF_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int unsigned i = 1; i <= 12; i++)
            begin
                den  = 64'((2 * i) * (2 * i + 1));
                term = udiv64((term * x2) >> 30, den);
                if ((i & 1) != 0)
                begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            tbl[k] = SINE_W'(v);
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

// ===== design/sine_tone_with_ramp_envelope.sv =====
// sine_tone_with_ramp_envelope: NCO tone segment generator, top level.
// Depends on stre_pkg (constants, state type, sine table).
`timescale 1ns / 1ps

// Usage
// -----
// Input channel (in_valid / in_stall / start_req): one item per output sample.
//   start_req = 1 restarts the segment at index zero and phase zero.
// Output channel (out_valid / out_stall / sample, last, active): one item per
//   input item. Outside a running segment the item is sample 0, active 0.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; write only while no item is in flight. Unknown indexes are
//   ignored. Writes take effect with the next input item.
// Flow: one item at a time. A running sample passes three times through the shared
//   24-step bit-serial multiplier (envelope phase, sine * amplitude, times gain),
//   plus setup and table reads, before the next accept. A sample outside a segment
//   skips the multiplier and goes straight to the output.
// Output register: the result sits in its own register, so the next item is
//   accepted while a result waits; if the receiver stalls, the finished next
//   result holds in the sequencer until the register frees up.
// Reset: asynchronous, active low. Registers return to their documented
//   defaults, phase and sample index clear, no segment runs.

module sine_tone_with_ramp_envelope (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stre_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stre_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  start_req,
    // output items
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [stre_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  last,
    output logic                                  active
);

    localparam int unsigned STB    = stre_pkg::SINE_TABLE_BITS;
    localparam int unsigned AW     = stre_pkg::ROM_ADDR_W;
    localparam int unsigned IW     = stre_pkg::INDEX_BITS;
    localparam int unsigned PW     = stre_pkg::PHASE_W;
    localparam int unsigned MAW    = stre_pkg::MUL_A_W;
    localparam int unsigned MBW    = stre_pkg::MUL_B_W;
    localparam int unsigned CW     = stre_pkg::CMP_W;
    localparam int unsigned PRW    = stre_pkg::PROD_W;
    localparam int unsigned SW     = stre_pkg::STEP_W;
    localparam int unsigned QB     = stre_pkg::QTURN_BIT;
    localparam int unsigned SMPW   = stre_pkg::SAMPLE_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PW-1:0]                    phase_step_reg;
    logic [stre_pkg::AMP_W-1:0]       amplitude_reg;
    logic [stre_pkg::TOTAL_W-1:0]     total_samples_reg;
    logic [stre_pkg::RLEN_W-1:0]      ramp_samples_reg;
    logic [stre_pkg::RSTEP_W-1:0]     ramp_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= stre_pkg::RST_PHASE_STEP;
            amplitude_reg     <= stre_pkg::RST_AMPLITUDE;
            total_samples_reg <= stre_pkg::RST_TOTAL_SAMPLES;
            ramp_samples_reg  <= stre_pkg::RST_RAMP_SAMPLES;
            ramp_step_reg     <= stre_pkg::RST_RAMP_STEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                stre_pkg::CFG_PHASE_STEP:
                    phase_step_reg <= cfg_data[PW-1:0];
                stre_pkg::CFG_AMPLITUDE:
                    amplitude_reg <= cfg_data[stre_pkg::AMP_W-1:0];
                stre_pkg::CFG_TOTAL_SAMPLES:
                    total_samples_reg <= cfg_data[stre_pkg::TOTAL_W-1:0];
                stre_pkg::CFG_RAMP_SAMPLES:
                    ramp_samples_reg <= cfg_data[stre_pkg::RLEN_W-1:0];
                stre_pkg::CFG_RAMP_STEP:
                    ramp_step_reg <= cfg_data[stre_pkg::RSTEP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and tone state
    // ------------------------------------------------------------------
    stre_pkg::stre_state_t state_reg, state_next;

    logic [PW-1:0] phase_acc_reg, phase_acc_next;
    logic [IW-1:0] sample_count_reg, sample_count_next;
    logic          running_reg, running_next;

    // per-item working registers
    logic [IW-1:0]              work_idx_reg;
    logic [AW-1:0]              sine_addr_reg;
    logic                       neg_reg;
    logic                       last_reg;
    logic                       active_reg;
    logic                       unity_reg;
    logic [stre_pkg::SINE_W-1:0] sine_reg;
    logic [stre_pkg::GAIN_W-1:0] gain_reg;

    // multiplier
    logic [MAW-1:0] mul_a_reg;
    logic [MBW-1:0] mul_b_reg;
    logic [MAW-1:0] mul_hi_reg;
    logic [MBW-1:0] mul_lo_reg;
    logic [SW-1:0]  step_cnt_reg;
    logic [MAW:0]   mul_sum;
    logic [PRW-1:0] prod;
    logic           mul_load;
    logic           mul_run;
    logic           mul_last_step;
    logic [MAW-1:0] mul_a_in;
    logic [MBW-1:0] mul_b_in;

    // sine table read port
    logic [AW-1:0]               rom_addr;
    logic [stre_pkg::SINE_W-1:0] rom_q_reg;

    // output register
    logic                  out_valid_reg;
    logic signed [SMPW-1:0] sample_reg;
    logic                  last_out_reg;
    logic                  active_out_reg;
    logic                  out_load;

    // ---- item acceptance: apply start, advance phase and index ----
    logic           accept;
    logic [IW-1:0]  eff_idx;
    logic [PW-1:0]  eff_phase;
    logic           eff_run;
    logic           eff_last;
    logic [STB-1:0] eff_ti;
    logic [AW-1:0]  eff_addr;

    assign in_stall = (state_reg != stre_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        eff_idx   = start_req ? '0 : sample_count_reg;
        eff_phase = start_req ? '0 : phase_acc_reg;
        eff_run   = start_req ? (total_samples_reg != '0) : running_reg;
        eff_last  = (CW'(eff_idx) + CW'(1)) >= CW'(total_samples_reg);
        // quadrant 1 and 3 read mirrored
        eff_ti    = eff_phase[QB-1 -: STB];
        eff_addr  = eff_phase[QB] ? (AW'(stre_pkg::TBL_N) - {1'b0, eff_ti})
                                  : {1'b0, eff_ti};

        phase_acc_next    = phase_acc_reg;
        sample_count_next = sample_count_reg;
        running_next      = running_reg;
        if (accept)
        begin
            phase_acc_next    = eff_run ? eff_phase + phase_step_reg : eff_phase;
            sample_count_next = eff_run ? eff_idx + IW'(1) : eff_idx;
            running_next      = eff_run && !eff_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stre_pkg::ST_IDLE;
            phase_acc_reg    <= '0;
            sample_count_reg <= '0;
            running_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_acc_reg    <= phase_acc_next;
            sample_count_reg <= sample_count_next;
            running_reg      <= running_next;
        end
    end

    // ---- envelope region (rise / fall / flat) from the latched index ----
    logic [CW-1:0]  idx_x;
    logic [CW-1:0]  ramp_x;
    logic [CW-1:0]  tot_x;
    logic           in_rise;
    logic           in_fall;
    logic [CW-1:0]  rel_dist;
    logic [MBW-1:0] env_dist;

    always_comb
    begin
        idx_x    = CW'(work_idx_reg);
        ramp_x   = CW'(ramp_samples_reg);
        tot_x    = CW'(total_samples_reg);
        in_rise  = idx_x < ramp_x;
        in_fall  = (idx_x + ramp_x) > tot_x;
        // past the end: release distance zero
        rel_dist = (tot_x > idx_x) ? tot_x - idx_x : '0;
        env_dist = in_rise ? MBW'(work_idx_reg) : rel_dist[MBW-1:0];
    end

    // ---- gain table address from envelope phase, saturated at a quarter turn
    logic           env_sat;
    logic [AW-1:0]  gain_addr;

    assign env_sat   = |prod[PRW-1:QB];
    assign gain_addr = env_sat ? AW'(stre_pkg::TBL_N) : {1'b0, prod[QB-1 -: STB]};

    // ---- bit-serial shift-add multiplier, LSB of the multiplier first ----
    assign mul_sum       = {1'b0, mul_hi_reg} + (mul_b_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign prod          = {mul_hi_reg, mul_lo_reg};
    assign mul_last_step = (step_cnt_reg == SW'(MBW - 1));

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_a_reg    <= mul_a_in;
            mul_b_reg    <= mul_b_in;
            mul_hi_reg   <= '0;
            mul_lo_reg   <= '0;
            step_cnt_reg <= '0;
        end
        else if (mul_run)
        begin
            mul_hi_reg   <= mul_sum[MAW:1];
            mul_lo_reg   <= {mul_sum[0], mul_lo_reg[MBW-1:1]};
            mul_b_reg    <= mul_b_reg >> 1;
            step_cnt_reg <= step_cnt_reg + SW'(1);
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        mul_load   = 1'b0;
        mul_run    = 1'b0;
        mul_a_in   = '0;
        mul_b_in   = '0;
        rom_addr   = sine_addr_reg;
        out_load   = 1'b0;

        unique case (state_reg)
            stre_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = eff_run ? stre_pkg::ST_ENV : stre_pkg::ST_DONE;
                end
            end
            stre_pkg::ST_ENV:
            begin
                mul_load   = 1'b1;
                mul_a_in   = ramp_step_reg;
                mul_b_in   = env_dist;
                state_next = stre_pkg::ST_MUL_ENV;
            end
            stre_pkg::ST_MUL_ENV:
            begin
                mul_run = 1'b1;
                if (mul_last_step)
                begin
                    state_next = stre_pkg::ST_GAIN_RD;
                end
            end
            stre_pkg::ST_GAIN_RD:
            begin
                rom_addr   = gain_addr;
                mul_load   = 1'b1;
                mul_a_in   = MAW'(sine_reg);
                mul_b_in   = MBW'(amplitude_reg);
                state_next = stre_pkg::ST_MUL_AMP;
            end
            stre_pkg::ST_MUL_AMP:
            begin
                mul_run = 1'b1;
                if (mul_last_step)
                begin
                    state_next = stre_pkg::ST_LOAD_GAIN;
                end
            end
            stre_pkg::ST_LOAD_GAIN:
            begin
                // sine * amplitude stays below 2^30
                mul_load   = 1'b1;
                mul_a_in   = MAW'(prod[QB-1:0]);
                mul_b_in   = MBW'(gain_reg);
                state_next = stre_pkg::ST_MUL_GAIN;
            end
            stre_pkg::ST_MUL_GAIN:
            begin
                mul_run = 1'b1;
                if (mul_last_step)
                begin
                    state_next = stre_pkg::ST_DONE;
                end
            end
            stre_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = stre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stre_pkg::ST_IDLE;
            end
        endcase
    end

    // ---- sine table, registered read ----
    always_ff @(posedge clk)
    begin
        rom_q_reg <= stre_pkg::SINE_TBL[rom_addr];
    end

    // ---- working registers ----
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_idx_reg  <= eff_idx;
            sine_addr_reg <= eff_addr;
            neg_reg       <= eff_phase[PW-1];
            last_reg      <= eff_run && eff_last;
            active_reg    <= eff_run;
        end
        if (state_reg == stre_pkg::ST_ENV)
        begin
            unity_reg <= !in_rise && !in_fall;
        end
        // table data for the sine lands in the first multiply cycle
        if (state_reg == stre_pkg::ST_MUL_ENV && step_cnt_reg == '0)
        begin
            sine_reg <= rom_q_reg;
        end
        if (state_reg == stre_pkg::ST_MUL_AMP && step_cnt_reg == '0)
        begin
            gain_reg <= unity_reg ? stre_pkg::UNITY_GAIN
                                  : stre_pkg::GAIN_W'(rom_q_reg);
        end
    end

    // ---- output register ----
    logic [SMPW-1:0] mag;

    assign mag = prod[QB + SMPW - 1 : QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (active_reg)
            begin
                sample_reg <= neg_reg ? $signed(SMPW'(0) - mag) : $signed(mag);
            end
            else
            begin
                sample_reg <= '0;
            end
            last_out_reg   <= last_reg;
            active_out_reg <= active_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_out_reg;
    assign active    = active_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // one item in flight: an accept always leaves the sequencer busy
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on back-to-back cycles");

    // samples outside a segment are silent and never close a segment
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !active) |-> (sample == '0 && !last))
        else $error("inactive item carries data");

    // the closing sample ends the segment
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> !running_reg)
        else $error("segment still running after its last sample");

endmodule
